FILE: rtl/spc_pkg.sv
`default_nettype none
package spc_pkg;

   localparam int MAX_POINTS = 256;
   localparam int COORD_W    = 16;

   localparam int ADDR_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W    = $clog2(MAX_POINTS + 1);
   localparam int LBL_W    = ADDR_W;

   localparam int THR_W     = 14;
   localparam int THR_RESET = 100;
   localparam int DIST_CAP  = 10000;

   localparam int INDEX_W = 8;
   localparam int TOTAL_W = 9;

   localparam int ABS_W = COORD_W + 1;
   localparam int SQ_W  = 2 * ABS_W;
   localparam int D2_W  = SQ_W + 1;
   localparam int T2_W  = 2 * THR_W;
   localparam int CMP_W = (D2_W > T2_W) ? D2_W : T2_W;

   typedef struct packed {
      logic [LBL_W-1:0]          label;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } entry_type;

endpackage
`default_nettype wire

FILE: rtl/sequential_point_clustering.sv
// Online single-linkage clustering of 2-D points. Each request beat carries one point; the
// block compares it with every stored point and assigns it to the earliest-created cluster
// that holds a point whose squared distance is strictly below the squared threshold, or
// opens a new cluster when none qualifies. req_start_set empties the store before the point.
// When the store is full the point is dropped and rsp_store_full is set. The block takes no
// new request beat until the current one has passed through scan and finish; a dropped
// point skips the scan. The point store is read one entry per cycle into a single pipelined
// distance unit, and req_ready stays low until the response beat is loaded into the output
// register, so a response beat still waiting there holds the block in its last step. The
// user must write the threshold through the csr_ port only while no item is in flight; the
// block itself does not enforce this. Its reset value is 100, and a threshold above 10000
// lets every point join the first existing cluster.
`default_nettype none
module sequential_point_clustering (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [spc_pkg::THR_W-1:0]           csr_distance_threshold,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_start_set,
   input  wire logic signed [spc_pkg::COORD_W-1:0]  req_point_x,
   input  wire logic signed [spc_pkg::COORD_W-1:0]  req_point_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [spc_pkg::INDEX_W-1:0]              rsp_cluster_index,
   output logic                                     rsp_opened_cluster,
   output logic                                     rsp_store_full,
   output logic [spc_pkg::TOTAL_W-1:0]              rsp_cluster_total
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type state_ff, state_in;

   logic [spc_pkg::THR_W-1:0]          thr_ff, thr_in;
   logic [spc_pkg::CNT_W-1:0]          pcount_ff, pcount_in;
   logic [spc_pkg::CNT_W-1:0]          ccount_ff, ccount_in;
   logic [spc_pkg::CNT_W-1:0]          issue_ff, issue_in;
   logic signed [spc_pkg::COORD_W-1:0] px_ff, px_in;
   logic signed [spc_pkg::COORD_W-1:0] py_ff, py_in;
   logic [spc_pkg::T2_W-1:0]           t2_ff, t2_in;
   logic                               capped_ff, capped_in;
   logic                               full_ff, full_in;
   logic                               found_ff, found_in;
   logic [spc_pkg::LBL_W-1:0]          best_ff, best_in;
   logic                               s1_vld_ff, s1_vld_in;
   logic                               s2_vld_ff, s2_vld_in;
   logic                               s3_vld_ff, s3_vld_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [spc_pkg::INDEX_W-1:0]        index_ff, index_in;
   logic                               opened_ff, opened_in;
   logic                               sfull_ff, sfull_in;
   logic [spc_pkg::TOTAL_W-1:0]        total_ff, total_in;

   spc_pkg::entry_type mem [spc_pkg::MAX_POINTS];
   spc_pkg::entry_type rd_ff;
   spc_pkg::entry_type wr_entry;

   logic [spc_pkg::ABS_W-1:0] adx_ff, ady_ff;
   logic [spc_pkg::LBL_W-1:0] lbl2_ff, lbl3_ff;
   logic [spc_pkg::SQ_W-1:0]  sqx_ff, sqy_ff;

   logic signed [spc_pkg::ABS_W-1:0] dx_diff, dy_diff;
   logic [spc_pkg::ABS_W-1:0]        adx, ady;
   logic [spc_pkg::D2_W-1:0]         d2;
   logic                             near;

   logic [spc_pkg::CNT_W-1:0]             base_cnt;
   logic                                  issue_more;
   logic                                  fin_go;
   logic [spc_pkg::LBL_W-1:0]             new_label;
   logic [spc_pkg::CNT_W-1:0]             ccount_next;
   logic [spc_pkg::LBL_W+spc_pkg::INDEX_W-1:0] index_ext;
   logic [spc_pkg::CNT_W+spc_pkg::TOTAL_W-1:0] total_ext;

   assign csr_ready          = 1'b1;
   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cluster_index  = index_ff;
   assign rsp_opened_cluster = opened_ff;
   assign rsp_store_full     = sfull_ff;
   assign rsp_cluster_total  = total_ff;

   // distance unit
   assign dx_diff = spc_pkg::ABS_W'(px_ff) - spc_pkg::ABS_W'(rd_ff.x);
   assign dy_diff = spc_pkg::ABS_W'(py_ff) - spc_pkg::ABS_W'(rd_ff.y);
   assign adx     = dx_diff[spc_pkg::ABS_W-1] ? spc_pkg::ABS_W'(-dx_diff)
                                              : spc_pkg::ABS_W'(dx_diff);
   assign ady     = dy_diff[spc_pkg::ABS_W-1] ? spc_pkg::ABS_W'(-dy_diff)
                                              : spc_pkg::ABS_W'(dy_diff);
   assign d2      = spc_pkg::D2_W'(sqx_ff) + spc_pkg::D2_W'(sqy_ff);
   assign near    = capped_ff ||
                    (spc_pkg::CMP_W'(d2) < spc_pkg::CMP_W'(t2_ff));

   assign base_cnt    = req_start_set ? '0 : pcount_ff;
   assign issue_more  = (state_ff == ST_SCAN) && (issue_ff != pcount_ff);
   assign fin_go      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign new_label   = found_ff ? best_ff : ccount_ff[spc_pkg::LBL_W-1:0];
   assign ccount_next = (found_ff || full_ff) ? ccount_ff : ccount_ff + 1'b1;
   assign index_ext   = {{spc_pkg::INDEX_W{1'b0}}, new_label};
   assign total_ext   = {{spc_pkg::TOTAL_W{1'b0}}, ccount_next};

   assign wr_entry.label = new_label;
   assign wr_entry.y     = py_ff;
   assign wr_entry.x     = px_ff;

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      pcount_in    = pcount_ff;
      ccount_in    = ccount_ff;
      issue_in     = issue_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      t2_in        = t2_ff;
      capped_in    = capped_ff;
      full_in      = full_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      s1_vld_in    = issue_more;
      s2_vld_in    = s1_vld_ff;
      s3_vld_in    = s2_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      index_in     = index_ff;
      opened_in    = opened_ff;
      sfull_in     = sfull_ff;
      total_in     = total_ff;

      if (csr_valid) begin
         thr_in = csr_distance_threshold;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               px_in     = req_point_x;
               py_in     = req_point_y;
               t2_in     = spc_pkg::T2_W'(thr_ff) * spc_pkg::T2_W'(thr_ff);
               capped_in = (thr_ff > spc_pkg::THR_W'(spc_pkg::DIST_CAP));
               issue_in  = '0;
               found_in  = 1'b0;
               best_in   = '0;
               pcount_in = base_cnt;
               if (req_start_set) begin
                  ccount_in = '0;
               end
               full_in  = (base_cnt == spc_pkg::CNT_W'(spc_pkg::MAX_POINTS));
               state_in = full_in ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_more) begin
               issue_in = issue_ff + 1'b1;
            end
            if (s3_vld_ff && near && (!found_ff || lbl3_ff < best_ff)) begin
               found_in = 1'b1;
               best_in  = lbl3_ff;
            end
            if (!issue_more && !s1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fin_go) begin
               rsp_valid_in = 1'b1;
               total_in     = total_ext[spc_pkg::TOTAL_W-1:0];
               ccount_in    = ccount_next;
               if (full_ff) begin
                  index_in  = '0;
                  opened_in = 1'b0;
                  sfull_in  = 1'b1;
               end else begin
                  index_in  = index_ext[spc_pkg::INDEX_W-1:0];
                  opened_in = !found_ff;
                  sfull_in  = 1'b0;
                  pcount_in = pcount_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= spc_pkg::THR_W'(spc_pkg::THR_RESET);
         pcount_ff    <= '0;
         ccount_ff    <= '0;
         issue_ff     <= '0;
         full_ff      <= 1'b0;
         found_ff     <= 1'b0;
         best_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         pcount_ff    <= pcount_in;
         ccount_ff    <= ccount_in;
         issue_ff     <= issue_in;
         full_ff      <= full_in;
         found_ff     <= found_in;
         best_ff      <= best_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         px_ff        <= px_in;
         py_ff        <= py_in;
         t2_ff        <= t2_in;
         capped_ff    <= capped_in;
         index_ff     <= index_in;
         opened_ff    <= opened_in;
         sfull_ff     <= sfull_in;
         total_ff     <= total_in;
      end
   end

   // point store: one read and one write port
   always_ff @(posedge clock) begin
      if (issue_more) begin
         rd_ff <= mem[issue_ff[spc_pkg::ADDR_W-1:0]];
      end
      if (fin_go && !full_ff) begin
         mem[pcount_ff[spc_pkg::ADDR_W-1:0]] <= wr_entry;
      end
   end

   // distance pipeline: abs difference, then squares
   always_ff @(posedge clock) begin
      adx_ff  <= adx;
      ady_ff  <= ady;
      lbl2_ff <= rd_ff.label;
      sqx_ff  <= spc_pkg::SQ_W'(adx_ff) * spc_pkg::SQ_W'(adx_ff);
      sqy_ff  <= spc_pkg::SQ_W'(ady_ff) * spc_pkg::SQ_W'(ady_ff);
      lbl3_ff <= lbl2_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (pcount_ff <= spc_pkg::CNT_W'(spc_pkg::MAX_POINTS)) && (ccount_ff <= pcount_ff))
      else $error("cluster or point count out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item is in flight");

   a_full_no_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_full) |-> (!rsp_opened_cluster && rsp_cluster_index == '0))
      else $error("dropped point reported a cluster");

   a_open_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_opened_cluster) |->
         (rsp_cluster_index == spc_pkg::INDEX_W'(rsp_cluster_total - 1'b1)))
      else $error("opened cluster is not the newest");

   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff))
      else $error("distance pipeline busy outside scan");

endmodule
`default_nettype wire

FILE: tb/spc_cluster_checker.sv
`timescale 1ns / 1ps
module spc_cluster_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [spc_pkg::THR_W-1:0]           csr_distance_threshold,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic                                req_start_set,
   input  wire logic signed [spc_pkg::COORD_W-1:0]  req_point_x,
   input  wire logic signed [spc_pkg::COORD_W-1:0]  req_point_y,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic [spc_pkg::INDEX_W-1:0]         rsp_cluster_index,
   input  wire logic                                rsp_opened_cluster,
   input  wire logic                                rsp_store_full,
   input  wire logic [spc_pkg::TOTAL_W-1:0]         rsp_cluster_total,
   output int                                       open_items,
   output int                                       mismatch_total
);
   import spc_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] cluster_index;
      logic               opened_cluster;
      logic               store_full;
      logic [TOTAL_W-1:0] cluster_total;
   } cluster_result_type;

   logic signed [COORD_W-1:0] member_x     [MAX_POINTS];
   logic signed [COORD_W-1:0] member_y     [MAX_POINTS];
   logic [LBL_W-1:0]          member_label [MAX_POINTS];
   int                        member_count;
   int                        cluster_count;
   logic [THR_W-1:0]          join_threshold;
   cluster_result_type        pending_assignments [$];

   function automatic cluster_result_type assign_point(input logic start,
                                                       input logic signed [COORD_W-1:0] px,
                                                       input logic signed [COORD_W-1:0] py);
      cluster_result_type r;
      longint          dx;
      longint          dy;
      longint          d2;
      longint          t2;
      logic            capped;
      logic            found;
      int              best;
      t2     = longint'(join_threshold) * longint'(join_threshold);
      capped = (join_threshold > DIST_CAP);
      found  = 1'b0;
      best   = 0;
      if (start) begin
         member_count  = 0;
         cluster_count = 0;
      end
      if (member_count >= MAX_POINTS) begin
         r.cluster_index  = '0;
         r.opened_cluster = 1'b0;
         r.store_full     = 1'b1;
         r.cluster_total  = cluster_count[TOTAL_W-1:0];
         return r;
      end
      for (int i = 0; i < member_count; i++) begin
         dx = longint'(px) - longint'(member_x[i]);
         dy = longint'(py) - longint'(member_y[i]);
         d2 = dx * dx + dy * dy;
         if ((capped || d2 < t2) && (!found || int'(member_label[i]) < best)) begin
            best  = int'(member_label[i]);
            found = 1'b1;
         end
      end
      if (!found) begin
         best = cluster_count;
         cluster_count++;
      end
      member_x[member_count]     = px;
      member_y[member_count]     = py;
      member_label[member_count] = best[LBL_W-1:0];
      member_count++;
      r.cluster_index  = best[INDEX_W-1:0];
      r.opened_cluster = !found;
      r.store_full     = 1'b0;
      r.cluster_total  = cluster_count[TOTAL_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      cluster_result_type want;
      cluster_result_type got;
      cluster_result_type fresh;
      if (reset) begin
         pending_assignments.delete();
         member_count   = 0;
         cluster_count  = 0;
         join_threshold = THR_W'(THR_RESET);
         open_items     = 0;
         mismatch_total = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.cluster_index  = rsp_cluster_index;
            got.opened_cluster = rsp_opened_cluster;
            got.store_full     = rsp_store_full;
            got.cluster_total  = rsp_cluster_total;
            if (pending_assignments.size() == 0) begin
               if (mismatch_total < 10)
                  $display("%0t: unexpected result beat index=%0d opened=%0d full=%0d total=%0d",
                           $realtime, got.cluster_index, got.opened_cluster, got.store_full,
                           got.cluster_total);
               mismatch_total++;
            end else begin
               want = pending_assignments.pop_front();
               if (got.cluster_index !== want.cluster_index ||
                   got.opened_cluster !== want.opened_cluster ||
                   got.store_full !== want.store_full ||
                   got.cluster_total !== want.cluster_total) begin
                  if (mismatch_total < 10)
                     $display("%0t: mismatch expected index=%0d opened=%0d full=%0d total=%0d, %s",
                              $realtime, want.cluster_index, want.opened_cluster,
                              want.store_full, want.cluster_total,
                              $sformatf("got index=%0d opened=%0d full=%0d total=%0d",
                                        got.cluster_index, got.opened_cluster,
                                        got.store_full, got.cluster_total));
                  mismatch_total++;
               end
            end
         end
         if (csr_valid && csr_ready)
            join_threshold = csr_distance_threshold;
         if (req_valid && req_ready) begin
            fresh = assign_point(req_start_set, req_point_x, req_point_y);
            pending_assignments = {pending_assignments, fresh};
         end
         open_items = pending_assignments.size();
      end
   end
endmodule

FILE: tb/tb_sequential_point_clustering.sv
`timescale 1ns / 1ps
module tb_sequential_point_clustering;
   import spc_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [THR_W-1:0]          csr_distance_threshold;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_start_set;
   logic signed [COORD_W-1:0] req_point_x;
   logic signed [COORD_W-1:0] req_point_y;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [INDEX_W-1:0]        rsp_cluster_index;
   logic                      rsp_opened_cluster;
   logic                      rsp_store_full;
   logic [TOTAL_W-1:0]        rsp_cluster_total;
   int                        open_items;
   int                        mismatch_total;

   int                        send_idle_pct;
   int                        rsp_idle_pct;
   int                        cur_threshold;

   sequential_point_clustering uut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_distance_threshold (csr_distance_threshold),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_start_set          (req_start_set),
      .req_point_x            (req_point_x),
      .req_point_y            (req_point_y),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_cluster_index      (rsp_cluster_index),
      .rsp_opened_cluster     (rsp_opened_cluster),
      .rsp_store_full         (rsp_store_full),
      .rsp_cluster_total      (rsp_cluster_total)
   );

   spc_cluster_checker chk (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_distance_threshold (csr_distance_threshold),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_start_set          (req_start_set),
      .req_point_x            (req_point_x),
      .req_point_y            (req_point_y),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_cluster_index      (rsp_cluster_index),
      .rsp_opened_cluster     (rsp_opened_cluster),
      .rsp_store_full         (rsp_store_full),
      .rsp_cluster_total      (rsp_cluster_total),
      .open_items             (open_items),
      .mismatch_total         (mismatch_total)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
      if (v > 32767)
         return 16'sh7fff;
      if (v < -32768)
         return 16'sh8000;
      return v[COORD_W-1:0];
   endfunction

   task automatic send_point(input logic start, input int x, input int y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_start_set <= start;
      req_point_x   <= clamp_coord(x);
      req_point_y   <= clamp_coord(y);
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_threshold(input int value);
      req_valid <= 1'b0;
      while (open_items != 0)
         @(negedge clock);
      csr_valid              <= 1'b1;
      csr_distance_threshold <= value[THR_W-1:0];
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid     <= 1'b0;
      cur_threshold = value;
   endtask

   task automatic run_batch(input int item_target, input bit with_fill);
      int  sent;
      int  seq_len;
      int  n_centers;
      int  spread;
      int  c;
      int  x;
      int  y;
      int  cx [4];
      int  cy [4];
      bit  fill_now;
      logic first_clear;
      logic st;
      sent = 0;
      if (cur_threshold == 0)
         spread = 2;
      else if (cur_threshold > DIST_CAP)
         spread = 20000;
      else
         spread = cur_threshold + cur_threshold / 2 + 1;
      while (sent < item_target) begin
         fill_now = with_fill;
         with_fill = 1'b0;
         if (fill_now)
            seq_len = $urandom_range(257, 270);
         else if ($urandom_range(29) == 0)
            seq_len = $urandom_range(40, 90);
         else
            seq_len = $urandom_range(1, 24);
         n_centers = $urandom_range(1, 4);
         for (int i = 0; i < n_centers; i++) begin
            cx[i] = int'($urandom_range(0, 65535)) - 32768;
            cy[i] = int'($urandom_range(0, 65535)) - 32768;
         end
         first_clear = fill_now || ($urandom_range(9) != 0);
         for (int k = 0; k < seq_len; k++) begin
            st = (k == 0) ? first_clear : (!fill_now && $urandom_range(49) == 0);
            if ($urandom_range(99) < 15) begin
               x = int'($urandom_range(0, 65535)) - 32768;
               y = int'($urandom_range(0, 65535)) - 32768;
            end else begin
               c = $urandom_range(0, n_centers - 1);
               x = cx[c] + int'($urandom_range(0, 2 * spread)) - spread;
               y = cy[c] + int'($urandom_range(0, 2 * spread)) - spread;
            end
            send_point(st, x, y);
            sent++;
         end
      end
   endtask

   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset                  = 1'b1;
      csr_valid              = 1'b0;
      csr_distance_threshold = '0;
      req_valid              = 1'b0;
      req_start_set          = 1'b0;
      req_point_x            = '0;
      req_point_y            = '0;
      send_idle_pct          = 34;
      rsp_idle_pct           = 82;
      cur_threshold          = THR_RESET;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset threshold: boundary, earliest cluster, coordinate extremes, restart
      send_point(1'b1, 0, 0);
      send_point(1'b0, 99, 0);
      send_point(1'b0, 199, 0);
      send_point(1'b0, 150, 0);
      send_point(1'b0, 32767, 32767);
      send_point(1'b0, -32768, -32768);
      send_point(1'b0, 32767, -32768);
      send_point(1'b0, -32768, 32767);
      send_point(1'b0, -1, -1);
      send_point(1'b1, 5, 5);

      set_threshold(0);
      send_point(1'b1, 0, 0);
      send_point(1'b0, 0, 0);
      send_point(1'b0, 0, 0);

      set_threshold((1 << THR_W) - 1);
      send_point(1'b1, 32767, 32767);
      send_point(1'b0, -32768, -32768);
      send_point(1'b0, 0, 0);

      set_threshold(DIST_CAP);
      send_point(1'b1, 0, 0);
      send_point(1'b0, 10000, 0);
      send_point(1'b0, 9999, 0);
      send_point(1'b0, -32768, -32768);

      set_threshold(DIST_CAP + 1);
      send_point(1'b1, -32768, -32768);
      send_point(1'b0, 32767, 32767);

      set_threshold(1);
      run_batch(300, 1'b1);
      set_threshold(THR_RESET);
      run_batch(150, 1'b0);
      set_threshold((1 << THR_W) - 1);
      run_batch(150, 1'b0);

      send_idle_pct = 82;
      rsp_idle_pct  = 34;
      set_threshold(0);
      run_batch(300, 1'b1);
      set_threshold(DIST_CAP);
      run_batch(150, 1'b0);
      set_threshold($urandom_range(0, (1 << THR_W) - 1));
      run_batch(150, 1'b0);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      set_threshold(DIST_CAP + 1);
      run_batch(300, 1'b1);
      set_threshold(2500);
      run_batch(150, 1'b0);
      set_threshold($urandom_range(0, (1 << THR_W) - 1));
      run_batch(150, 1'b0);

      req_valid <= 1'b0;
      while (open_items != 0)
         @(negedge clock);
      repeat (300) @(negedge clock);
      if (mismatch_total == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/spc_pkg.sv
rtl/sequential_point_clustering.sv
tb/spc_cluster_checker.sv
tb/tb_sequential_point_clustering.sv
